// ===== src/sida_pkg.sv =====
package sida_pkg;

  // Decimal digits needed for a 32-bit magnitude
  localparam int NDIG  = 10;
  localparam int MAG_W = 32;
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef logic [3:0] digit_t;

  // Controller sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  // Control broadcast to every digit cell
  typedef struct packed {
    logic clr;
    logic shift;
    logic bit_in;
  } cell_ctrl_t;

endpackage

// ===== src/sida_in_if.sv =====
interface sida_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [15:0] capacity;

  modport source (output valid, output value, output capacity, input ready);
  modport sink   (input valid, input value, input capacity, output ready);
endinterface

// ===== src/sida_out_if.sv =====
interface sida_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       fits;
  logic [3:0] count;

  modport source (output valid, output character, output last, output fits,
                  output count, input ready);
  modport sink   (input valid, input character, input last, input fits,
                  input count, output ready);
endinterface

// ===== src/sida_bcd_cell.sv =====
module sida_bcd_cell
  import sida_pkg::*;
(
  input  logic   clk,
  input  logic   clr,
  input  logic   shift,
  input  logic   carry_in,
  output logic   carry_out,
  output digit_t digit
);

  digit_t digit_r;
  digit_t digit_nxt;
  digit_t adj;

  // add-3 correction ahead of the doubling shift
  always_comb begin
    adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    carry_out = adj[3];
    digit_nxt = {adj[2:0], carry_in};
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      digit_r <= '0;
    end else if (shift) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

// ===== src/sida_digit_chain.sv =====
module sida_digit_chain
  import sida_pkg::*;
(
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  output digit_t [NDIG-1:0]     digits
);

  logic [NDIG-1:0] carry;

  // cell 0 holds the units digit; binary bits enter there
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic cin;
    if (i == 0) begin : g_first
      assign cin = ctrl.bit_in;
    end else begin : g_next
      assign cin = carry[i-1];
    end

    sida_bcd_cell u_cell (
      .clk       (clk),
      .clr       (ctrl.clr),
      .shift     (ctrl.shift),
      .carry_in  (cin),
      .carry_out (carry[i]),
      .digit     (digits[i])
    );
  end

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit to decimal ASCII converter. One input beat (value, capacity)
// yields one output beat per character: '-' for a negative value, then the
// digits most significant first without leading zeros ("0" for zero). When
// sign plus digits do not fit in capacity minus one, a single beat with
// character 0, fits 0 and count 0 is sent instead. The last beat carries the
// character count. Items are handled one at a time: after acceptance the
// magnitude is shifted bit by bit through a row of ten BCD digit cells,
// a sizing state then sizes the text, and one beat per cycle leaves
// when the output side is ready, N characters in all (N from 1 to 11).
// The last beat of one item can still wait in the output register while
// the next item is already accepted and converted.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sida_in_if.sink     in_bus,
  sida_out_if.source  out_bus
);

  state_t            state_r, state_nxt;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic [15:0]       cap_r;
  logic [CNT_W-1:0]  bit_cnt_r;
  logic [3:0]        ndig_r, len_r, pos_r;
  logic              fit_r;

  logic              out_valid_r;
  logic [7:0]        char_r;
  logic              last_r, fits_r;
  logic [3:0]        count_r;

  cell_ctrl_t        ctrl;
  digit_t [NDIG-1:0] digits;
  logic              accept, slot_free, emit;
  logic [3:0]        ndig_c, len_c, dig_idx;
  logic              emit_last;
  logic [7:0]        char_c;

  sida_digit_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .digits (digits)
  );

  assign slot_free = !out_valid_r || out_bus.ready;
  assign emit_last = !fit_r || (pos_r == len_r - 4'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_bus.valid) state_nxt = ST_CONV;
      ST_CONV: if (bit_cnt_r == CNT_W'(MAG_W - 1)) state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free && emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_bus.ready = (state_r == ST_IDLE);
    accept       = (state_r == ST_IDLE) && in_bus.valid;
    ctrl.clr     = accept;
    ctrl.shift   = (state_r == ST_CONV);
    ctrl.bit_in  = mag_r[MAG_W-1];
    emit         = (state_r == ST_EMIT) && slot_free;
  end

  // significant digit count, zero still gives one digit
  always_comb begin
    ndig_c = 4'd1;
    for (int i = 0; i < NDIG; i++) begin
      if (digits[i] != '0) ndig_c = 4'(i + 1);
    end
    len_c = ndig_c + {3'b0, neg_r};
  end

  // character for the current position
  always_comb begin
    dig_idx = ndig_r + {3'b0, neg_r} - 4'd1 - pos_r;
    if (!fit_r) begin
      char_c = '0;
    end else if (neg_r && pos_r == '0) begin
      char_c = CHAR_MINUS;
    end else begin
      char_c = CHAR_ZERO + {4'b0, digits[dig_idx]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r     <= in_bus.value[MAG_W-1];
      mag_r     <= in_bus.value[MAG_W-1] ? (~in_bus.value + 32'd1) : in_bus.value;
      cap_r     <= in_bus.capacity;
      bit_cnt_r <= '0;
    end else if (state_r == ST_CONV) begin
      mag_r     <= {mag_r[MAG_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + CNT_W'(1);
    end
    if (state_r == ST_SIZE) begin
      ndig_r <= ndig_c;
      len_r  <= len_c;
      fit_r  <= ({12'b0, len_c} < cap_r);
      pos_r  <= '0;
    end else if (emit) begin
      pos_r <= pos_r + 4'd1;
    end
    if (emit) begin
      char_r  <= char_c;
      last_r  <= emit_last;
      fits_r  <= fit_r;
      count_r <= (emit_last && fit_r) ? len_r : 4'd0;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.character = char_r;
  assign out_bus.last      = last_r;
  assign out_bus.fits      = fits_r;
  assign out_bus.count     = count_r;

endmodule

// ===== dv/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb;
  import sida_pkg::*;

  localparam int RANDOM_NUMBERS = 360;
  // Longest quiet stretch is conversion plus a long stall, far below this
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] capacity;
  } number_beat_t;

  typedef struct {
    number_beat_t beat;
    bit           drain_first;
  } queued_number_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       fits;
    logic [3:0] count;
  } text_beat_t;

  logic clk;
  logic rst_n;

  sida_in_if  in_ch ();
  sida_out_if out_ch ();

  signed_int_to_decimal_ascii dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  queued_number_t pending_numbers[$];
  text_beat_t     expected_text[$];
  text_beat_t     got_beat;
  text_beat_t     want_beat;

  int total_numbers;
  int accepted_numbers;
  int errors;
  int idle_cycles;
  int gap_left;
  int stall_left;
  bit send_steady;
  bit take_steady;

  // Decimal text of one number, pushed as the beats the block must send
  function automatic void predict_text(logic [31:0] value, logic [15:0] capacity);
    logic [31:0] mag;
    logic [3:0]  rev [NDIG];
    logic        neg;
    int          ndig;
    int          len;
    text_beat_t  tb;
    neg  = value[31];
    mag  = neg ? (~value + 32'd1) : value;
    ndig = 0;
    do begin
      rev[ndig] = 4'(mag % 32'd10);
      mag       = mag / 32'd10;
      ndig++;
    end while (mag != 0);
    len = ndig + int'(neg);
    // text plus terminator must fit; otherwise a single empty beat
    if (len >= int'(capacity)) begin
      tb = '{symbol: 8'h00, last: 1'b1, fits: 1'b0, count: 4'd0};
      expected_text.push_back(tb);
      return;
    end
    for (int i = 0; i < len; i++) begin
      if (neg && i == 0) tb.symbol = CHAR_MINUS;
      else tb.symbol = CHAR_ZERO + 8'(rev[len - 1 - i]);
      tb.last  = (i == len - 1);
      tb.fits  = 1'b1;
      tb.count = tb.last ? 4'(len) : 4'd0;
      expected_text.push_back(tb);
    end
  endfunction

  function automatic int text_length(logic [31:0] value);
    logic [31:0] mag;
    int          n;
    mag = value[31] ? (~value + 32'd1) : value;
    n   = int'(value[31]);
    do begin
      n++;
      mag = mag / 32'd10;
    end while (mag != 0);
    return n;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic void add_number(logic [31:0] value, logic [15:0] capacity,
                                     bit drain_first = 1'b0);
    queued_number_t q;
    q.beat.value    = value;
    q.beat.capacity = capacity;
    q.drain_first   = drain_first;
    pending_numbers.push_back(q);
  endfunction

  // Random number of chosen length, capacity mostly around the text length
  function automatic void add_random_number(bit drain_first);
    logic [31:0] base;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mag;
    logic [31:0] value;
    logic [15:0] capacity;
    int          digits;
    int          len;
    int          pick;
    bit          neg;
    if ($urandom_range(0, 99) < 15) begin
      value = $urandom();
    end else begin
      digits = $urandom_range(1, 10);
      neg    = $urandom_range(0, 1);
      base   = 1;
      repeat (digits - 1) base = base * 10;
      lo = (digits == 1) ? 32'd0 : base;
      if (digits == 10) hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else hi = base * 10 - 1;
      mag   = $urandom_range(hi, lo);
      value = neg ? (~mag + 32'd1) : mag;
    end
    len  = text_length(value);
    pick = $urandom_range(0, 99);
    if (pick < 55) capacity = 16'(len + 1 + $urandom_range(0, 3));
    else if (pick < 70) capacity = 16'(len);
    else if (pick < 80) capacity = 16'(len + 1);
    else if (pick < 88) capacity = 16'($urandom_range(0, len));
    else capacity = 16'($urandom());
    add_number(value, capacity, drain_first);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Source side: one beat held until taken, gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.value, in_ch.capacity);
        accepted_numbers++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if ($urandom_range(0, 299) == 0) send_steady = !send_steady;
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_numbers.size() == 0 ||
                     (pending_numbers[0].drain_first && expected_text.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.value    <= pending_numbers[0].beat.value;
          in_ch.capacity <= pending_numbers[0].beat.capacity;
          in_ch.valid    <= 1'b1;
          void'(pending_numbers.pop_front());
          gap_left = send_steady ? 0 : pick_idle();
        end
      end
    end
  end

  // Sink side: check each text beat, stall ready at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_beat = '{symbol: out_ch.character, last: out_ch.last,
                     fits: out_ch.fits, count: out_ch.count};
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: char %h last %b fits %b count %0d",
                   $time, got_beat.symbol, got_beat.last, got_beat.fits, got_beat.count);
        end else begin
          want_beat = expected_text.pop_front();
          if (got_beat != want_beat) begin
            errors++;
            $display("%0t: mismatch: expected char %h last %b fits %b count %0d, actual char %h last %b fits %b count %0d",
                     $time, want_beat.symbol, want_beat.last, want_beat.fits,
                     want_beat.count, got_beat.symbol, got_beat.last, got_beat.fits,
                     got_beat.count);
          end
        end
      end
      if ($urandom_range(0, 299) == 0) take_steady = !take_steady;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!take_steady) stall_left = pick_idle();
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d beats still expected", $time, expected_text.size());
        $display("signed_int_to_decimal_ascii_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.capacity = '0;
    out_ch.ready   = 1'b0;

    // Directed: zero, one digit, sign, extremes, exact fit and one short
    add_number(32'd0, 16'd0);
    add_number(32'd0, 16'd1);
    add_number(32'd0, 16'd2);
    add_number(32'd9, 16'hFFFF);
    add_number(32'd10, 16'd3);
    add_number(32'd10, 16'd2);
    add_number(-32'sd1, 16'd3);
    add_number(-32'sd1, 16'd2);
    add_number(-32'sd7, 16'd1);
    add_number(-32'sd10, 16'd4);
    add_number(32'h7FFF_FFFF, 16'd11);
    add_number(32'h7FFF_FFFF, 16'd10);
    // most negative value goes through its unsigned magnitude
    add_number(32'h8000_0000, 16'd12, 1'b1);
    add_number(32'h8000_0000, 16'd11);
    add_number(32'h8000_0000, 16'hFFFF);
    add_number(32'd1000000000, 16'hFFFF);
    add_number(32'd999999999, 16'd10);
    add_number(-32'sd999999999, 16'd11);
    add_number(32'd123456789, 16'd0);
    add_number(32'h5555_5555, 16'hAAAA);
    add_number(32'hAAAA_AAAA, 16'h5555);
    add_number(32'd1, 16'h8000);

    for (int i = 0; i < RANDOM_NUMBERS; i++) add_random_number(i == RANDOM_NUMBERS / 2);
    total_numbers = pending_numbers.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_numbers < total_numbers) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii_tb: done, clean");
    end else begin
      $display("signed_int_to_decimal_ascii_tb: done, errors");
    end
    $finish;
  end

endmodule
